### sv/medip_pkg.sv
// Shared constants, register indexes and helpers of the MED inverse predictor.
`timescale 1ns / 1ps

package medip_pkg;

  // Fixed widths of the stream beats and configuration fields
  localparam int DATA_W     = 64;
  localparam int ROW_CFG_W  = 13;
  localparam int ESIZE_W    = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = ROW_CFG_W;

  // Defaults of the top-level parameters
  localparam int DEF_MAX_ROW_WIDTH    = 4096;
  localparam int DEF_MAX_ELEMENT_BITS = 64;

  // Register reset values
  localparam logic [ROW_CFG_W-1:0] ROW_WIDTH_RESET = 13'd4096;
  localparam logic [ESIZE_W-1:0]   ESIZE_RESET     = 2'd0;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_SIZE = 1'b1;

  // Element mask for a size code: 8 << code low bits set
  function automatic logic [DATA_W-1:0] elem_mask(input logic [ESIZE_W-1:0] code);
    logic [DATA_W-1:0] m;
    logic [7:0]        bits;
    bits = 8'd8 << code;
    for (int i = 0; i < DATA_W; i++) begin
      m[i] = (8'(i) < bits);
    end
    return m;
  endfunction

endpackage

### sv/med_inverse_predictor.sv
// Top level of the MED inverse predictor: line store, neighbour registers and output skid.
`timescale 1ns / 1ps

// Channel   Dir  Payload                                 Handshake
// s_*       in   tdata = residual[63:0], tlast = EOI     s_tvalid_i / s_tready_o
// m_*       out  tdata = pixel[63:0], tlast = last pixel m_tvalid_o / m_tready_i
// cfg_*     in   idx 0 = row_width, 1 = element_size     cfg_we_i, no wait
//
// One pixel leaves per residual, one beat per cycle while the sink keeps up;
// each pixel is registered in the output register, or in the skid on a stall.
// The rate is set by the left-neighbour loop (compare, select, add on W) and the
// line store, read a column ahead so N is ready for the next beat.
// Reset sets the first-row flag, clears column, neighbours and all valid flags; the
// line store needs no clearing since each row is read only after being written.
// A two-entry output stage (register plus skid) keeps s_tready_o registered and
// lets one more beat enter while a result waits on a stalled m_tready_i.

module med_inverse_predictor
  import medip_pkg::*;
#(
  parameter int MAX_ROW_WIDTH    = DEF_MAX_ROW_WIDTH,
  parameter int MAX_ELEMENT_BITS = DEF_MAX_ELEMENT_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // stream in
  input  logic                  s_tvalid_i,
  output logic                  s_tready_o,
  input  logic [DATA_W-1:0]     s_tdata_i,   // [63:0] residual
  input  logic                  s_tlast_i,   // end_of_image
  // stream out
  output logic                  m_tvalid_o,
  input  logic                  m_tready_i,
  output logic [DATA_W-1:0]     m_tdata_o,   // [63:0] pixel
  output logic                  m_tlast_o,   // last_pixel
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int EW    = MAX_ELEMENT_BITS;
  localparam int CW    = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
  localparam int CNT_W = CW + 1;
  localparam int WW    = (CNT_W > ROW_CFG_W) ? CNT_W : ROW_CFG_W;

  // Configuration registers
  logic [ROW_CFG_W-1:0] row_width_q;
  logic [ESIZE_W-1:0]   esize_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= ROW_WIDTH_RESET;
      esize_q     <= ESIZE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROW_WIDTH:    row_width_q <= cfg_data_i[ROW_CFG_W-1:0];
        CFG_ELEMENT_SIZE: esize_q     <= cfg_data_i[ESIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective element mask and row width
  logic [DATA_W-1:0] mask_full;
  logic [EW-1:0]     mask;
  logic [WW-1:0]     rw_ext;
  logic [WW-1:0]     width_eff;

  assign mask_full = elem_mask(esize_q);
  assign mask      = mask_full[EW-1:0];
  assign rw_ext    = WW'(row_width_q);

  always_comb begin
    if (rw_ext < WW'(2)) begin
      width_eff = WW'(2);
    end else if (rw_ext > WW'(MAX_ROW_WIDTH)) begin
      width_eff = WW'(MAX_ROW_WIDTH);
    end else begin
      width_eff = rw_ext;
    end
  end

  // Scan state
  logic [CW-1:0] col_q, col_d;
  logic          first_q, first_d;
  logic [EW-1:0] left_q, left_d;
  logic [EW-1:0] ul_q, ul_d;

  // Output stage
  logic              out_v_q, skid_v_q;
  logic [EW-1:0]     out_pix_q, skid_pix_q;
  logic              out_last_q, skid_last_q;

  logic accept, pop;
  assign s_tready_o = !skid_v_q;
  assign accept     = s_tvalid_i && s_tready_o;
  assign pop        = out_v_q && m_tready_i;

  // Line store: read one column ahead, registered read data
  logic [EW-1:0] line_mem [MAX_ROW_WIDTH];
  logic [EW-1:0] north_q;
  logic [CW-1:0] rd_addr;
  logic [EW-1:0] pix;

  assign rd_addr = accept ? col_d : col_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      line_mem[col_q] <= pix;
    end
    north_q <= line_mem[rd_addr];
  end

  // Prediction
  logic [EW-1:0] res, w, n, nw, lo, hi, med, pred;

  assign res = s_tdata_i[EW-1:0] & mask;
  assign w   = left_q & mask;
  assign n   = north_q & mask;
  assign nw  = ul_q & mask;
  assign lo  = (w < n) ? w : n;
  assign hi  = (w < n) ? n : w;

  always_comb begin
    if (nw >= hi) begin
      med = lo;
    end else if (nw <= lo) begin
      med = hi;
    end else begin
      med = w + n - nw;
    end
    if (first_q) begin
      pred = (col_q == '0) ? '0 : w;
    end else begin
      pred = (col_q == '0) ? n : med;
    end
  end

  assign pix = (res + pred) & mask;

  // Next scan state
  logic [CNT_W-1:0] col_inc;
  logic             row_end;

  assign col_inc = CNT_W'(col_q) + CNT_W'(1);
  assign row_end = (WW'(col_inc) >= width_eff);

  always_comb begin
    col_d   = col_q;
    first_d = first_q;
    left_d  = left_q;
    ul_d    = ul_q;
    if (accept) begin
      left_d = pix;
      if (!first_q) begin
        ul_d = n;
      end
      if (s_tlast_i) begin
        // image done: start fresh on a first row
        col_d   = '0;
        first_d = 1'b1;
        left_d  = '0;
        ul_d    = '0;
      end else if (row_end) begin
        col_d   = '0;
        first_d = 1'b0;
      end else begin
        col_d = col_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
      left_q  <= '0;
      ul_q    <= '0;
    end else begin
      col_q   <= col_d;
      first_q <= first_d;
      left_q  <= left_d;
      ul_q    <= ul_d;
    end
  end

  // Output register and skid: a new beat goes to the skid only when the
  // output register is held by a stalled sink.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (accept) begin
        if (!out_v_q || pop) begin
          out_v_q <= 1'b1;
        end else begin
          skid_v_q <= 1'b1;
        end
      end else if (pop) begin
        if (skid_v_q) begin
          skid_v_q <= 1'b0;
        end else begin
          out_v_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (!out_v_q || pop) begin
        out_pix_q  <= pix;
        out_last_q <= s_tlast_i;
      end else begin
        skid_pix_q  <= pix;
        skid_last_q <= s_tlast_i;
      end
    end else if (pop && skid_v_q) begin
      out_pix_q  <= skid_pix_q;
      out_last_q <= skid_last_q;
    end
  end

  assign m_tvalid_o = out_v_q;
  assign m_tdata_o  = DATA_W'(out_pix_q);
  assign m_tlast_o  = out_last_q;

  // Assertions
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid holds a beat while the output register is empty");

  a_accept_gives_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> m_tvalid_o)
    else $error("accepted beat produced no output");

  a_col_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(col_q) < CNT_W'(MAX_ROW_WIDTH))
    else $error("column beyond line store depth");

  a_eoi_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && s_tlast_i) |=> (col_q == '0) && first_q && (left_q == '0))
    else $error("end of image did not restart the scan");

  a_no_skid_overrun : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_v_q && !pop) |=> skid_v_q && $stable(skid_pix_q))
    else $error("skid beat lost while the sink stalls");

endmodule

### bench/med_inverse_predictor_test.sv
// Self-checking bench for the MED inverse predictor: directed rows, random images, back-pressure.
`timescale 1ns / 1ps

module med_inverse_predictor_test;
  import medip_pkg::*;

  localparam int CLK_PERIOD      = 10;
  localparam int RESET_CYCLES    = 9;
  localparam int STALL_LIMIT     = 4000;  // cycles with no beat on either side
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int REPORT_LIMIT    = 10;
  localparam int LINE_DEPTH      = DEF_MAX_ROW_WIDTH;
  localparam int MIN_ROW         = 2;
  localparam int TAIL_CYCLES     = 20;
  localparam int PHASE_ITEMS     = 165;
  localparam int WIDE_ROW_ITEMS  = 40;

  // Element width codes of the element_size register
  localparam logic [ESIZE_W-1:0] ESIZE_8  = 2'd0;
  localparam logic [ESIZE_W-1:0] ESIZE_16 = 2'd1;
  localparam logic [ESIZE_W-1:0] ESIZE_32 = 2'd2;
  localparam logic [ESIZE_W-1:0] ESIZE_64 = 2'd3;

  typedef struct packed {
    logic [DATA_W-1:0] pixel;
    logic              last;
  } pixel_beat_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  s_tvalid_i = 1'b0;
  logic                  s_tready_o;
  logic [DATA_W-1:0]     s_tdata_i  = '0;   // [63:0] residual
  logic                  s_tlast_i  = 1'b0; // end_of_image
  logic                  m_tvalid_o;
  logic                  m_tready_i = 1'b0;
  logic [DATA_W-1:0]     m_tdata_o;         // [63:0] pixel
  logic                  m_tlast_o;         // last_pixel
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  med_inverse_predictor u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tlast_i  (s_tlast_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Shadow of the block: registers, line store and neighbour state as reset leaves them.
  // The line store is left unknown; the stimulus never reads an entry before writing it.
  logic [ROW_CFG_W-1:0] row_width_reg = ROW_WIDTH_RESET;
  logic [ESIZE_W-1:0]   esize_reg     = ESIZE_RESET;
  logic [DATA_W-1:0]    line_store [LINE_DEPTH];
  int unsigned          col_pos       = 0;
  bit                   first_row     = 1'b1;
  logic [DATA_W-1:0]    west_pix      = '0;
  logic [DATA_W-1:0]    northwest_pix = '0;

  pixel_beat_t pending_pixels[$];  // pixels still owed by the block, oldest first
  int          mismatches     = 0;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_left      = 0;  // cycles the output side still refuses beats
  int          idle_cycles    = 0;

  function automatic logic [DATA_W-1:0] element_mask();
    int bits;
    bits = 8 << esize_reg;
    if (bits >= DATA_W) begin
      return {DATA_W{1'b1}};
    end
    return (64'd1 << bits) - 64'd1;
  endfunction

  // Row width as the block applies it: clamp into 2..line depth
  function automatic int unsigned eff_row_width();
    if (row_width_reg < MIN_ROW) begin
      return MIN_ROW;
    end
    if (row_width_reg > LINE_DEPTH) begin
      return LINE_DEPTH;
    end
    return row_width_reg;
  endfunction

  // Rebuild one pixel from its residual and advance the raster position
  function automatic pixel_beat_t rebuild_pixel(input logic [DATA_W-1:0] residual,
                                                input logic eoi);
    logic [DATA_W-1:0] mask, res, north, w_m, nw_m, lo, hi, guess, pix;
    int unsigned       width, col;
    pixel_beat_t       beat;
    mask  = element_mask();
    res   = residual & mask;
    width = eff_row_width();
    col   = (col_pos >= LINE_DEPTH) ? LINE_DEPTH - 1 : col_pos;
    w_m   = west_pix & mask;
    nw_m  = northwest_pix & mask;
    if (first_row) begin
      // first row: pass the very first pixel, then add the left neighbour
      pix = (col == 0) ? res : res + w_m;
    end else begin
      north = line_store[col] & mask;
      if (col == 0) begin
        pix = res + north;
      end else begin
        // median edge: clip to min/max of W and N when NW lies outside them
        lo = (w_m < north) ? w_m : north;
        hi = (w_m < north) ? north : w_m;
        if (nw_m >= hi) begin
          guess = lo;
        end else if (nw_m <= lo) begin
          guess = hi;
        end else begin
          guess = w_m + north - nw_m;
        end
        pix = res + guess;
      end
      northwest_pix = north;
    end
    pix             = pix & mask;
    line_store[col] = pix;
    west_pix        = pix;
    if (eoi) begin
      col_pos       = 0;
      first_row     = 1'b1;
      west_pix      = '0;
      northwest_pix = '0;
    end else if (col + 1 >= width) begin
      col_pos   = 0;
      first_row = 1'b0;
    end else begin
      col_pos = col + 1;
    end
    beat.pixel = pix;
    beat.last  = eoi;
    return beat;
  endfunction

  // Offer one residual beat after a random idle gap; predict once it is taken
  task automatic send_residual(input logic [DATA_W-1:0] residual, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= residual;
    s_tlast_i  <= eoi;
    @(posedge clk_i);
    while (!s_tready_o) begin
      @(posedge clk_i);
    end
    pending_pixels.push_back(rebuild_pixel(residual, eoi));
  endtask

  // Drop valid and hold until every owed pixel has left, plus the pipeline latency
  task automatic wait_drained();
    s_tvalid_i <= 1'b0;
    while (pending_pixels.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == CFG_ROW_WIDTH) begin
      row_width_reg = value;
    end else begin
      esize_reg = value[ESIZE_W-1:0];
    end
  endtask

  // Write both registers; the size word carries junk above the code bits
  task automatic set_format(input logic [ROW_CFG_W-1:0] width, input logic [ESIZE_W-1:0] code);
    logic [CFG_DATA_W-1:0] size_word;
    size_word                = CFG_DATA_W'($urandom);
    size_word[ESIZE_W-1:0]   = code;
    write_reg(CFG_ROW_WIDTH, width);
    write_reg(CFG_ELEMENT_SIZE, size_word);
  endtask

  // Mostly full random words, with extremes and tiny values mixed in to hit every MED branch
  function automatic logic [DATA_W-1:0] pick_residual();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return DATA_W'($urandom_range(3));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly narrow rows; now and then wider, or below the floor of two
  function automatic logic [ROW_CFG_W-1:0] pick_row_width();
    case ($urandom_range(9))
      0:       return ROW_CFG_W'($urandom_range(2));
      1:       return ROW_CFG_W'($urandom_range(33, 9));
      default: return ROW_CFG_W'($urandom_range(8, 2));
    endcase
  endfunction

  // Reset state: 4096-pixel rows, 8-bit elements; short image ending inside the first row
  task automatic test_reset_defaults();
    send_residual('0, 1'b0);
    send_residual('1, 1'b0);
    send_residual(64'h80, 1'b0);
    send_residual(64'h7F, 1'b1);
  endtask

  // Row width written below the floor; values steer through the three MED branches
  task automatic test_narrow_rows();
    wait_drained();
    set_format(13'd0, ESIZE_8);
    send_residual(64'd200, 1'b0);
    send_residual(64'd100, 1'b0);
    send_residual(64'd10, 1'b0);
    send_residual(64'd5, 1'b0);   // NW between W and N
    send_residual(64'd255, 1'b0);
    send_residual(64'd1, 1'b1);   // NW above both
    wait_drained();
    set_format(13'd1, ESIZE_16);
    send_residual(64'hFFFF_0000_0000_0000, 1'b0);  // junk above the element is masked
    send_residual(64'hABCD_0000_0000_0010, 1'b0);
    send_residual(64'h0000_1234_0000_0020, 1'b0);
    send_residual('1, 1'b1);      // NW below both
  endtask

  // Full 64-bit elements: sums wrap at the top of the word
  task automatic test_wide_elements();
    wait_drained();
    set_format(13'd2, ESIZE_64);
    send_residual('1, 1'b0);
    send_residual('1, 1'b0);
    send_residual(64'h8000_0000_0000_0000, 1'b0);
    send_residual('1, 1'b1);
  endtask

  // Registers changed inside an image: shrink the row below the current column and widen
  // the element; the next pixel closes the row
  task automatic test_mid_image_change();
    wait_drained();
    set_format(13'd4, ESIZE_8);
    for (int i = 0; i < 7; i++) begin
      send_residual(pick_residual(), 1'b0);
    end
    wait_drained();
    set_format(13'd2, ESIZE_64);
    send_residual(pick_residual(), 1'b0);
    send_residual(pick_residual(), 1'b0);
    send_residual(pick_residual(), 1'b1);
  endtask

  // Whole images with random formats; reformat only between images so that a row
  // never grows inside an image and every line store read follows its write
  task automatic run_random_phase(input int n_items, input int idle_pct, input int stall_pct);
    int          sent;
    int          rows;
    int unsigned width, end_col;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent           = 0;
    while (sent < n_items) begin
      if (sent == 0 || $urandom_range(99) < 35) begin
        wait_drained();
        set_format(pick_row_width(), ESIZE_W'($urandom_range(3)));
      end
      width   = eff_row_width();
      rows    = $urandom_range(5, 1);
      // most images end on a row boundary, some cut the last row short
      end_col = ($urandom_range(99) < 80) ? width - 1 : $urandom_range(width - 1);
      for (int r = 0; r < rows; r++) begin
        for (int unsigned c = 0; c < width; c++) begin
          if (r == rows - 1 && c > end_col) begin
            break;
          end
          send_residual(pick_residual(), r == rows - 1 && c == end_col);
          sent++;
        end
      end
    end
  endtask

  // Hold the output off for a long stretch while the input keeps offering beats,
  // so the block fills and lowers s_tready_o
  task automatic test_output_hold_off();
    wait_drained();
    set_format(13'd3, ESIZE_32);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = HOLD_OFF_CYCLES;
    for (int i = 0; i < 30; i++) begin
      send_residual(pick_residual(), i == 29);
    end
  endtask

  // Row width written above the line depth acts as the full depth: a short image
  // that stays inside the first row
  task automatic test_widest_row();
    wait_drained();
    set_format(13'h1FFF, ESIZE_16);
    send_idle_pct  = 18;
    recv_stall_pct = 18;
    for (int i = 0; i < WIDE_ROW_ITEMS; i++) begin
      send_residual(pick_residual(), i == WIDE_ROW_ITEMS - 1);
    end
  endtask

  // Output side: check each pixel beat against the oldest prediction, then pick the
  // next tready from the hold-off count or the stall rate
  always @(posedge clk_i) begin
    pixel_beat_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: pixel beat with none expected: pixel %h last %b",
                   $realtime, m_tdata_o, m_tlast_o);
        end
      end else begin
        want = pending_pixels.pop_front();
        if (m_tdata_o !== want.pixel || m_tlast_o !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: mismatch: pixel exp %h got %h, last exp %b got %b",
                     $realtime, want.pixel, m_tdata_o, want.last, m_tlast_o);
          end
        end
      end
    end
    if (hold_left > 0) begin
      m_tready_i <= 1'b0;
      hold_left--;
    end else begin
      m_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("** med_inverse_predictor: FAILED **");
        $finish;
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_narrow_rows();
    test_wide_elements();
    test_mid_image_change();

    // random images under each idling pattern
    run_random_phase(PHASE_ITEMS, 0, 0);
    run_random_phase(PHASE_ITEMS, 61, 0);
    run_random_phase(PHASE_ITEMS, 0, 61);
    run_random_phase(PHASE_ITEMS, 18, 18);

    test_output_hold_off();
    test_widest_row();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("** med_inverse_predictor: PASSED **");
    end else begin
      $display("** med_inverse_predictor: FAILED **");
    end
    $finish;
  end

endmodule
